// ===== src/kmct_pkg.sv =====
// Package for the key matrix change tracker.
// Holds the command and result codes, the configuration register indexes
// and the load record passed from the top level to the event merger.
package kmct_pkg;

  localparam logic [1:0] CMD_SCAN  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_GHOST = 2'd2;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_GHOST = 1'b1;

  localparam logic CFG_PRESENT_LOW  = 1'b0;
  localparam logic CFG_PRESENT_HIGH = 1'b1;

  localparam int MAX_COLS  = 8;
  localparam int MAX_ROWS  = 16;
  localparam int PRES_BITS = 64;

  // Work handed to the merger when an item is taken in.
  typedef struct packed {
    logic                scan;
    logic                ghost;
    logic [3:0]          row;
    logic [MAX_COLS-1:0] chg;
    logic [MAX_COLS-1:0] lev;
    logic [MAX_ROWS-1:0] rr;
    logic [MAX_COLS-1:0] rc;
  } kmct_load_t;

endpackage

// ===== src/key_matrix_change_tracker_top.sv =====
// Top level of the key matrix change tracker: key state, present masks,
// column lanes and the merging stage. Depends on kmct_pkg, kmct_lane and
// kmct_merge.
//
// Usage: items enter on the s_axis channel (tuser holds the command) and
// results leave on m_axis (tuser holds the kind, tlast marks the final
// result of an item). The present masks must be written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; nothing enforces it.
// A scan compares the row against the stored bits in all column lanes in
// the cycle it is accepted; the merger then issues one change event per
// cycle in column order while the receiver is ready. The first result
// passes through the merger's pending bits, then the output register.
// A scan keeps the input busy until its change events are issued (not at
// all when nothing changed), a ghost query until its answer is issued and
// a set not at all; the single event issue port sets that occupancy.
// Reset clears all key bits and sets both present masks to all ones.
// When the receiver stalls, the output register holds its result and the
// next result waits in the merger; the input stays ready until an item
// leaves results pending.
module key_matrix_change_tracker_top import kmct_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // row, col, col_levels, pressed, active_rows,
                                      // active_cols, rowed_rows_in, rowed_cols_in
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_row, event_col, event_level,
                                      // rowed_rows_out, rowed_cols_out
  output logic [0:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColIdxW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [1:0]          cmd;
  logic [3:0]          row;
  logic [2:0]          col;
  logic [7:0]          col_levels;
  logic                pressed;
  logic [15:0]         active_rows;
  logic [7:0]          active_cols;
  logic [15:0]         rowed_rows_in;
  logic [7:0]          rowed_cols_in;

  logic [COLS-1:0]     key_bits_q [ROWS];
  logic [COLS-1:0]     key_bits_d [ROWS];
  logic [PRES_BITS-1:0] present_q [2];
  logic [PRES_BITS-1:0] present_d [2];

  logic                in_fire;
  logic                busy;
  logic                row_ok;
  logic                col_ok;
  logic [RowIdxW-1:0]  row_idx;
  logic [ColIdxW-1:0]  col_idx;
  logic [COLS-1:0]     stored_row;
  logic [7:0]          pres_byte;
  logic [ROWS-1:0]     col_bits [COLS];
  logic [COLS-1:0]     chg;
  logic [COLS-1:0]     col_hit;
  logic [MAX_ROWS-1:0] row_hit;
  kmct_load_t          load;

  assign cmd           = s_axis_tuser;
  assign row           = s_axis_tdata[3:0];
  assign col           = s_axis_tdata[6:4];
  assign col_levels    = s_axis_tdata[14:7];
  assign pressed       = s_axis_tdata[15];
  assign active_rows   = s_axis_tdata[31:16];
  assign active_cols   = s_axis_tdata[39:32];
  assign rowed_rows_in = s_axis_tdata[55:40];
  assign rowed_cols_in = s_axis_tdata[63:56];

  assign s_axis_tready = ~busy;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign row_ok  = {1'b0, row} < 5'(ROWS);
  assign col_ok  = {1'b0, col} < 4'(COLS);
  assign row_idx = row[RowIdxW-1:0];
  assign col_idx = col[ColIdxW-1:0];

  assign stored_row = key_bits_q[row_idx];
  assign pres_byte  = present_q[row[3]][8*row[2:0] +: 8];

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        col_bits[c][r] = key_bits_q[r][c];
      end
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    kmct_lane #(
      .ROWS(ROWS)
    ) u_lane (
      .col_bits_i(col_bits[c]),
      .stored_i  (stored_row[c]),
      .present_i (pres_byte[c]),
      .level_i   (col_levels[c]),
      .active_i  (active_cols[c]),
      .change_o  (chg[c]),
      .hit_o     (col_hit[c])
    );
  end

  always_comb begin
    row_hit = '0;
    for (int r = 0; r < ROWS; r++) begin
      row_hit[r] = active_rows[r] & (|key_bits_q[r]);
    end
  end

  always_comb begin
    load       = '0;
    load.row   = row;
    load.chg   = MAX_COLS'(chg);
    load.lev   = col_levels;
    load.rr    = rowed_rows_in | row_hit;
    load.rc    = rowed_cols_in | MAX_COLS'(col_hit);
    if (in_fire) begin
      case (cmd)
        CMD_SCAN:  load.scan  = row_ok;
        CMD_GHOST: load.ghost = 1'b1;
        default:   ;
      endcase
    end
  end

  always_comb begin
    key_bits_d = key_bits_q;
    if (in_fire && cmd == CMD_SET && row_ok && col_ok) begin
      key_bits_d[row_idx][col_idx] = pressed;
    end
  end

  always_comb begin
    present_d = present_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESENT_LOW:  present_d[0] = cfg_data_i;
        CFG_PRESENT_HIGH: present_d[1] = cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        key_bits_q[r] <= '0;
      end
      present_q[0] <= '1;
      present_q[1] <= '1;
    end else begin
      key_bits_q <= key_bits_d;
      present_q  <= present_d;
    end
  end

  kmct_merge #(
    .COLS(COLS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .busy_o       (busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== src/kmct_lane.sv =====
// One column lane of the key matrix change tracker.
// Compares the scanned level with the stored bit and checks the whole
// column for pressed keys. Uses nothing outside this file.
module kmct_lane #(
  parameter int ROWS = 16
) (
  input  logic [ROWS-1:0] col_bits_i,
  input  logic            stored_i,
  input  logic            present_i,
  input  logic            level_i,
  input  logic            active_i,
  output logic            change_o,
  output logic            hit_o
);

  assign change_o = present_i & (stored_i ^ level_i);
  // A ghost query marks an active column when any row holds a pressed key here.
  assign hit_o    = active_i & (|col_bits_i);

endmodule

// ===== src/kmct_merge.sv =====
// Merging stage of the key matrix change tracker.
// Collects the lane results and emits them one transfer per cycle when not
// stalled, in column order, from its output register. Depends on kmct_pkg.
module kmct_merge import kmct_pkg::*; #(
  parameter int COLS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kmct_load_t  load_i,
  output logic        busy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_row, event_col, event_level,
                                      // rowed_rows_out, rowed_cols_out
  output logic [0:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  logic [MAX_COLS-1:0] pend_q, pend_d;
  logic [MAX_COLS-1:0] lev_q, lev_d;
  logic [3:0]          row_q, row_d;
  logic                gpend_q, gpend_d;
  logic [MAX_ROWS-1:0] grr_q, grr_d;
  logic [MAX_COLS-1:0] grc_q, grc_d;
  logic                ovalid_q, ovalid_d;
  logic [31:0]         odata_q, odata_d;
  logic                okind_q, okind_d;
  logic                olast_q, olast_d;

  logic [2:0]          pick_idx;
  logic [MAX_COLS-1:0] pick_oh;
  logic                avail;
  logic                adv;

  always_comb begin
    pick_idx = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (pend_q[c]) begin
        pick_idx = 3'(c);
      end
    end
  end

  assign pick_oh = MAX_COLS'(1) << pick_idx;
  assign avail   = gpend_q | (|pend_q);
  assign adv     = avail & (~ovalid_q | m_axis_tready);
  assign busy_o  = avail;

  always_comb begin
    pend_d   = pend_q;
    lev_d    = lev_q;
    row_d    = row_q;
    gpend_d  = gpend_q;
    grr_d    = grr_q;
    grc_d    = grc_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    okind_d  = okind_q;
    olast_d  = olast_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    if (adv) begin
      ovalid_d = 1'b1;
      if (gpend_q) begin
        gpend_d = 1'b0;
        okind_d = KIND_GHOST;
        olast_d = 1'b1;
        odata_d = {grc_q, grr_q, 1'b0, 3'd0, 4'd0};
      end else begin
        pend_d  = pend_q & ~pick_oh;
        okind_d = KIND_EVENT;
        olast_d = ((pend_q & ~pick_oh) == '0);
        odata_d = {8'd0, 16'd0, lev_q[pick_idx], pick_idx, row_q};
      end
    end

    // New work is taken only while nothing is pending.
    if (load_i.scan) begin
      pend_d = load_i.chg;
      lev_d  = load_i.lev;
      row_d  = load_i.row;
    end
    if (load_i.ghost) begin
      gpend_d = 1'b1;
      grr_d   = load_i.rr;
      grc_d   = load_i.rc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      gpend_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      gpend_q  <= gpend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lev_q   <= lev_d;
    row_q   <= row_d;
    grr_q   <= grr_d;
    grc_q   <= grc_d;
    odata_q <= odata_d;
    okind_q <= okind_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tdata    = odata_q;
  assign m_axis_tuser[0] = okind_q;
  assign m_axis_tlast    = olast_q;

  a_ghost_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && okind_q == KIND_GHOST |-> olast_q)
    else $error("ghost answer without last");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.scan || load_i.ghost |-> !avail)
    else $error("work loaded while results pending");

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gpend_q && pend_q != '0))
    else $error("scan and ghost work pending together");

  a_ghost_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.ghost |=> gpend_q)
    else $error("ghost query lost");

endmodule
